// ----- rtl/u8rve_pkg.sv -----
// Package for the UTF-8 run validator / JSON escaper.
// Holds the shared types, codes and escape-byte helpers.
// No dependencies.
package u8rve_pkg;

  // Working buffer: up to three held bytes plus the new one
  typedef logic [3:0][7:0] buf_t;
  typedef logic [2:0]      cnt_t;

  typedef enum logic [1:0] {
    ESC_FFFD,
    ESC_2028,
    ESC_2029
  } esc_e;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_COPY,
    ACT_ESC
  } act_e;

  typedef struct packed {
    act_e       kind;
    esc_e       code;
    logic [2:0] emit_len;
    logic [2:0] consume;
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT,
    ST_FLUSH
  } state_e;

  typedef enum logic {
    CFG_VALIDATE   = 1'b0,
    CFG_LINE_TERMS = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] LeadE2    = 8'hE2;
  localparam logic [7:0] Cont80    = 8'h80;
  localparam logic [7:0] TermA8    = 8'hA8;
  localparam logic [7:0] TermA9    = 8'hA9;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharU     = 8'h75;
  localparam logic [2:0] EscLen    = 3'd6;

  function automatic logic [15:0] esc_code(esc_e c);
    logic [15:0] v;
    case (c)
      ESC_2028: v = 16'h2028;
      ESC_2029: v = 16'h2029;
      default:  v = 16'hFFFD;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] v;
    if (nib < 4'd10) begin
      v = 8'h30 + {4'h0, nib};
    end else begin
      v = 8'h57 + {4'h0, nib};
    end
    return v;
  endfunction

  // Byte idx of the six-byte \uXXXX escape
  function automatic logic [7:0] esc_byte(esc_e c, logic [2:0] idx);
    logic [15:0] cp;
    logic [7:0]  v;
    cp = esc_code(c);
    case (idx)
      3'd0:    v = CharBslash;
      3'd1:    v = CharU;
      3'd2:    v = hex_char(cp[15:12]);
      3'd3:    v = hex_char(cp[11:8]);
      3'd4:    v = hex_char(cp[7:4]);
      default: v = hex_char(cp[3:0]);
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/u8rve_intf.sv -----
// Valid/ready channel interfaces for input bytes, output bytes and config writes.
// Depends on nothing.
interface u8rve_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       run_last;
  modport source (output valid, output in_byte, output run_last, input ready);
  modport sink   (input valid, input in_byte, input run_last, output ready);
endinterface

interface u8rve_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       run_end;
  modport source (output valid, output out_byte, output out_last, output run_end,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input run_end,
                  output ready);
endinterface

interface u8rve_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/utf8_run_validate_escape_top.sv -----
// Top level: byte sequencer around the shared head classifier and escape generator.
// Depends on u8rve_pkg, u8rve_intf and u8rve_decide.
//
//   channel | dir | beat fields
//   in_i    | in  | in_byte[7:0], run_last
//   out_o   | out | out_byte[7:0], out_last, run_end
//   cfg_i   | in  | index (0 validate_utf8, 1 escape_line_terms), data
//
// An item is accepted in idle; then each decided head is classified and its bytes are
// emitted one byte at a time, held while out_o stalls (1..4 copied, 6 for an escape);
// then a closing classify step runs and, if a beat is held, the final beat is released.
// The classifier is shared and the emit path is one byte wide.
// Reset clears the held-byte count, config flags and handshake state; held bytes are
// not cleared. in_i.ready is high only in idle; out_o stalls hold the emit loop.
module utf8_run_validate_escape_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8rve_in_if.sink    in_i,
  u8rve_out_if.source out_o,
  u8rve_cfg_if.sink   cfg_i
);

  u8rve_pkg::state_e state_q, state_d;
  u8rve_pkg::buf_t   buf_q, buf_d;
  u8rve_pkg::cnt_t   cnt_q, cnt_d;
  u8rve_pkg::act_t   act_now, act_q;
  logic [2:0]        idx_q, idx_d;
  logic              last_q, val_q, lt_q;
  logic              hold_v_q;
  logic [7:0]        hold_byte_q;
  logic              out_valid_q, out_last_q, run_end_q;
  logic [7:0]        out_byte_q;

  logic       in_ready, in_fire, out_free, emit_adv, emit_done;
  logic       push_out, push_last;
  logic [7:0] gen_byte;

  u8rve_decide u_decide (
    .buf_i  (buf_q),
    .cnt_i  (cnt_q),
    .val_i  (val_q),
    .lt_i   (lt_q),
    .last_i (last_q),
    .act_o  (act_now)
  );

  // Control outputs
  always_comb begin
    in_ready  = (state_q == u8rve_pkg::ST_IDLE);
    in_fire   = in_i.valid && in_ready;
    out_free  = !out_valid_q || out_o.ready;
    emit_adv  = (state_q == u8rve_pkg::ST_EMIT) && (!hold_v_q || out_free);
    emit_done = emit_adv && (idx_q == act_q.emit_len - 3'd1);
    push_last = (state_q == u8rve_pkg::ST_FLUSH) && out_free;
    push_out  = (emit_adv && hold_v_q) || push_last;
    if (act_q.kind == u8rve_pkg::ACT_ESC) begin
      gen_byte = u8rve_pkg::esc_byte(act_q.code, idx_q);
    end else begin
      gen_byte = buf_q[idx_q[1:0]];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      u8rve_pkg::ST_IDLE: begin
        if (in_fire) state_d = u8rve_pkg::ST_DECIDE;
      end
      u8rve_pkg::ST_DECIDE: begin
        if (act_now.kind != u8rve_pkg::ACT_NONE) begin
          state_d = u8rve_pkg::ST_EMIT;
        end else if (hold_v_q) begin
          state_d = u8rve_pkg::ST_FLUSH;
        end else begin
          state_d = u8rve_pkg::ST_IDLE;
        end
      end
      u8rve_pkg::ST_EMIT: begin
        if (emit_done) state_d = u8rve_pkg::ST_DECIDE;
      end
      u8rve_pkg::ST_FLUSH: begin
        if (out_free) state_d = u8rve_pkg::ST_IDLE;
      end
      default: state_d = u8rve_pkg::ST_IDLE;
    endcase
  end

  // Buffer load, shift-out of consumed bytes and emit index
  always_comb begin
    logic [2:0] src;
    src   = 3'd0;
    buf_d = buf_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (in_fire) begin
      buf_d[cnt_q[1:0]] = in_i.in_byte;
      cnt_d = cnt_q + 3'd1;
    end else if (emit_done) begin
      for (int i = 0; i < 4; i++) begin
        src = 3'(i) + act_q.consume;
        if (src < 3'd4) buf_d[i] = buf_q[src[1:0]];
      end
      cnt_d = cnt_q - act_q.consume;
    end
    if (state_q == u8rve_pkg::ST_DECIDE) begin
      idx_d = 3'd0;
    end else if (emit_adv) begin
      idx_d = idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= u8rve_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      val_q       <= 1'b0;
      lt_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (emit_adv) begin
        hold_v_q <= 1'b1;
      end else if (push_last) begin
        hold_v_q <= 1'b0;
      end
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (u8rve_pkg::cfg_idx_e'(cfg_i.index))
          u8rve_pkg::CFG_VALIDATE:   val_q <= cfg_i.data;
          u8rve_pkg::CFG_LINE_TERMS: lt_q  <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (in_fire) last_q <= in_i.run_last;
    if (state_q == u8rve_pkg::ST_DECIDE) act_q <= act_now;
    if (emit_adv) hold_byte_q <= gen_byte;
    if (push_out) begin
      out_byte_q <= hold_byte_q;
      out_last_q <= push_last;
      run_end_q  <= last_q;
    end
  end

  assign in_i.ready     = in_ready;
  assign cfg_i.ready    = 1'b1;
  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;
  assign out_o.run_end  = run_end_q;

  a_ready_hold_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !hold_v_q)
    else $error("input taken while a beat is still held");

  a_idle_cnt_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == u8rve_pkg::ST_IDLE) |-> (cnt_q <= 3'd3))
    else $error("more than three bytes held between items");

  a_emit_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == u8rve_pkg::ST_EMIT) |-> (idx_q < act_q.emit_len))
    else $error("emit index past the action length");

  a_flush_marks_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_last |=> (out_valid_q && out_last_q))
    else $error("closing beat not marked last");

endmodule

// ----- rtl/u8rve_decide.sv -----
// Head classifier: decides what the byte at the head of the buffer becomes.
// Uses u8rve_pkg types.
module u8rve_decide (
  input  u8rve_pkg::buf_t buf_i,
  input  u8rve_pkg::cnt_t cnt_i,
  input  logic            val_i,
  input  logic            lt_i,
  input  logic            last_i,
  output u8rve_pkg::act_t act_o
);

  logic [7:0]  b0, b1, b2, b3;
  logic [2:0]  need;
  logic [15:0] cp3;
  logic [20:0] cp4;
  logic        ok;
  logic        lt_hit;

  assign b0 = buf_i[0];
  assign b1 = buf_i[1];
  assign b2 = buf_i[2];
  assign b3 = buf_i[3];

  assign cp3 = {b0[3:0], b1[5:0], b2[5:0]};
  assign cp4 = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};

  always_comb begin
    if (!val_i) begin
      need = (b0 == u8rve_pkg::LeadE2) ? 3'd3 : 3'd1;
    end else if (b0[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (b0[7:4] == 4'b1110) begin
      need = 3'd3;
    end else if (b0[7:3] == 5'b11110) begin
      need = 3'd4;
    end else begin
      need = 3'd1;
    end
  end

  always_comb begin
    case (need)
      3'd1: ok = !b0[7];
      3'd2: ok = (b1[7:6] == 2'b10) && (b0[4:0] >= 5'd2);
      3'd3: ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (cp3 >= 16'h0800) &&
                 !((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
      3'd4: ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10) &&
                 (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);
      default: ok = 1'b0;
    endcase
  end

  assign lt_hit = lt_i && (b0 == u8rve_pkg::LeadE2) && (b1 == u8rve_pkg::Cont80) &&
                  ((b2 == u8rve_pkg::TermA8) || (b2 == u8rve_pkg::TermA9));

  always_comb begin
    act_o.kind     = u8rve_pkg::ACT_NONE;
    act_o.code     = u8rve_pkg::ESC_FFFD;
    act_o.emit_len = 3'd1;
    act_o.consume  = 3'd1;
    if (cnt_i == 3'd0) begin
      act_o.kind = u8rve_pkg::ACT_NONE;
    end else if (!val_i && !lt_i) begin
      act_o.kind = u8rve_pkg::ACT_COPY;
    end else if (cnt_i < need) begin
      // truncated head: decide only at the end of the run
      if (!last_i) begin
        act_o.kind = u8rve_pkg::ACT_NONE;
      end else if (val_i) begin
        act_o.kind     = u8rve_pkg::ACT_ESC;
        act_o.emit_len = u8rve_pkg::EscLen;
      end else begin
        act_o.kind = u8rve_pkg::ACT_COPY;
      end
    end else if (lt_hit) begin
      act_o.kind     = u8rve_pkg::ACT_ESC;
      act_o.code     = (b2 == u8rve_pkg::TermA8) ? u8rve_pkg::ESC_2028 : u8rve_pkg::ESC_2029;
      act_o.emit_len = u8rve_pkg::EscLen;
      act_o.consume  = 3'd3;
    end else if (!val_i) begin
      act_o.kind = u8rve_pkg::ACT_COPY;
    end else if (ok) begin
      act_o.kind     = u8rve_pkg::ACT_COPY;
      act_o.emit_len = need;
      act_o.consume  = need;
    end else begin
      act_o.kind     = u8rve_pkg::ACT_ESC;
      act_o.emit_len = u8rve_pkg::EscLen;
    end
  end

endmodule
